/* sv/iqd_pkg.sv */
package iqd_pkg;

  // default number of message entries in the ring
  localparam int unsigned QueueDepthDefault = 256;

  // item operation codes
  typedef enum logic [1:0] {
    OpEnqueue   = 2'd0,
    OpTrigger   = 2'd1,
    OpWriteFlag = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    StEnqueued  = 3'd0,
    StOnFire    = 3'd1,
    StQueueing  = 3'd2,
    StNoneQueued = 3'd3,
    StDelivered = 3'd4,
    StNoHandler = 3'd5,
    StFlagWritten = 3'd6
  } status_e;

  // input word
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] message;
    logic        queueing_value;
    logic [15:0] cpu_pc;
    logic [15:0] cpu_a;
    logic [15:0] cpu_sp;
    logic [15:0] handler_address;
  } in_word_t;

  // result word
  typedef struct packed {
    status_e     status;
    logic        delivered;
    logic [15:0] first_push_address;
    logic [15:0] first_push_data;
    logic [15:0] second_push_address;
    logic [15:0] second_push_data;
    logic [15:0] new_a;
    logic [15:0] new_pc;
    logic [15:0] new_sp;
    logic        on_fire;
    logic [8:0]  queued_count;
  } out_word_t;

  // ring control from the top level
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  // ring occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } ring_flags_t;

endpackage

/* sv/iqd_ring.sv */
module iqd_ring #(
  parameter int unsigned QueueDepth = iqd_pkg::QueueDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  iqd_pkg::ring_ctrl_t               ctrl_i,
  input  logic [15:0]                       wdata_i,
  output iqd_pkg::ring_flags_t              flags_o,
  output logic [$clog2(QueueDepth+1)-1:0]   count_o,
  output logic [15:0]                       rdata_o
);
  import iqd_pkg::*;

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(QueueDepth - 1);

  logic [15:0]      mem_q [QueueDepth];
  logic [15:0]      rdata_q;
  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;

  // pointer and occupancy update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d = (tail_q == LastAddr) ? '0 : tail_q + AddrW'(1);
    end
    if (ctrl_i.pop) begin
      head_d = (head_q == LastAddr) ? '0 : head_q + AddrW'(1);
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // message storage, write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= wdata_i;
    end
    if (ctrl_i.pop) begin
      rdata_q <= mem_q[head_q];
    end
  end

  assign flags_o.empty = (count_q == '0);
  assign flags_o.full  = (count_q == CntW'(QueueDepth));
  assign count_o       = count_q;
  assign rdata_o       = rdata_q;

endmodule

/* sv/interrupt_queue_delivery.sv */
// result path: an accepted word is registered into the message read stage and
//   then into the output register, which drives the result on the output
// throughput: one word per cycle; input stalls only when the message read
//   stage and the output register are both full and the output is stalled
// reset: pointers, count, queueing and fire flags clear at once; the
//   message ring itself is not cleared and is read only after a write
module interrupt_queue_delivery #(
  parameter int unsigned QueueDepth = iqd_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iqd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iqd_pkg::out_word_t out_word_o
);
  import iqd_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ring_ctrl_t      ring_ctrl;
  ring_flags_t     ring_flags;
  logic [CntW-1:0] ring_count;
  logic [15:0]     ring_rdata;

  logic            accept;
  logic            s1_adv;
  logic [CntW-1:0] cnt_after;
  logic [31:0]     cnt_wide;

  logic            queueing_q, queueing_d;
  logic            fire_q, fire_d;
  logic            s1_valid_q, s1_valid_d;
  status_e         s1_status_q, s1_status_d;
  logic            s1_deliv_q, s1_deliv_d;
  logic [15:0]     s1_pc_q, s1_a_q, s1_sp_q, s1_ha_q;
  logic            s1_fire_q;
  logic [8:0]      s1_count_q;
  logic            out_valid_q;
  out_word_t       out_q, out_d;

  iqd_ring #(
    .QueueDepth(QueueDepth)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .wdata_i(in_word_i.message),
    .flags_o(ring_flags),
    .count_o(ring_count),
    .rdata_o(ring_rdata)
  );

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // decode of the accepted word against current queue state
  always_comb begin
    ring_ctrl   = '0;
    queueing_d  = queueing_q;
    fire_d      = fire_q;
    s1_status_d = StEnqueued;
    s1_deliv_d  = 1'b0;
    s1_valid_d  = 1'b0;
    if (accept) begin
      case (in_word_i.op)
        OpEnqueue: begin
          s1_valid_d = 1'b1;
          if (ring_flags.full) begin
            fire_d      = 1'b1;
            s1_status_d = StOnFire;
          end else begin
            ring_ctrl.push = 1'b1;
            s1_status_d    = StEnqueued;
          end
        end
        OpTrigger: begin
          s1_valid_d = 1'b1;
          if (queueing_q) begin
            s1_status_d = StQueueing;
          end else if (ring_flags.empty) begin
            s1_status_d = StNoneQueued;
          end else begin
            ring_ctrl.pop = 1'b1;
            if (in_word_i.handler_address != 16'd0) begin
              queueing_d  = 1'b1;
              s1_deliv_d  = 1'b1;
              s1_status_d = StDelivered;
            end else begin
              s1_status_d = StNoHandler;
            end
          end
        end
        OpWriteFlag: begin
          s1_valid_d  = 1'b1;
          queueing_d  = in_word_i.queueing_value;
          s1_status_d = StFlagWritten;
        end
        default: begin
          s1_valid_d = 1'b0;
        end
      endcase
    end
  end

  // occupancy after this word
  assign cnt_after = ring_ctrl.push ? ring_count + CntW'(1) :
                     ring_ctrl.pop  ? ring_count - CntW'(1) : ring_count;
  assign cnt_wide  = 32'(cnt_after);

  // control state and message read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queueing_q  <= 1'b0;
      fire_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      queueing_q <= queueing_d;
      fire_q     <= fire_d;
      if (accept) begin
        s1_valid_q <= s1_valid_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= s1_status_d;
      s1_deliv_q  <= s1_deliv_d;
      s1_pc_q     <= in_word_i.cpu_pc;
      s1_a_q      <= in_word_i.cpu_a;
      s1_sp_q     <= in_word_i.cpu_sp;
      s1_ha_q     <= in_word_i.handler_address;
      s1_fire_q   <= fire_d;
      s1_count_q  <= cnt_wide[8:0];
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  // result assembly, push addresses wrap at 16 bits
  always_comb begin
    out_d              = '0;
    out_d.status       = s1_status_q;
    out_d.delivered    = s1_deliv_q;
    out_d.on_fire      = s1_fire_q;
    out_d.queued_count = s1_count_q;
    if (s1_deliv_q) begin
      out_d.first_push_address  = s1_sp_q - 16'd1;
      out_d.first_push_data     = s1_pc_q;
      out_d.second_push_address = s1_sp_q - 16'd2;
      out_d.second_push_data    = s1_a_q;
      out_d.new_a               = ring_rdata;
      out_d.new_pc              = s1_ha_q;
      out_d.new_sp              = s1_sp_q - 16'd2;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  // input stalls only when both stages hold a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o))
    else $error("input stalled with a free stage");

  // fire flag is sticky until reset
  a_fire_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_q |=> fire_q)
    else $error("fire flag cleared");

  // ring never holds more than its depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_count <= CntW'(QueueDepth))
    else $error("ring count beyond depth");

  // a delivery leaves queueing on
  a_deliver_queueing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_deliv_d) |=> queueing_q)
    else $error("delivery without queueing set");
`endif

endmodule
